// ----- src/mono_midi_to_cv_converter_top_macros.svh -----
// Assertion macros shared by the converter's modules.
// Each macro checks an implication on the rising clock edge and is quiet in reset.
`ifndef MONO_MIDI_TO_CV_CONVERTER_TOP_MACROS_SVH
`define MONO_MIDI_TO_CV_CONVERTER_TOP_MACROS_SVH

`ifndef SYNTH
// Consequent must hold in the same cycle as the antecedent
`define MMC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Consequent must hold in the cycle after the antecedent
`define MMC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MMC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define MMC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- src/mmc_pkg.sv -----
package mmc_pkg;

    // MIDI status nibbles
    localparam logic [3:0] NIB_NOTE_OFF = 4'h8;
    localparam logic [3:0] NIB_NOTE_ON  = 4'h9;
    localparam logic [3:0] NIB_CTRL     = 4'hB;

    // Controller number for all notes off
    localparam logic [6:0] CC_ALL_NOTES_OFF = 7'h7B;

    // Accepted MIDI message lengths
    localparam logic [2:0] MSG_LEN_SHORT = 3'd2;
    localparam logic [2:0] MSG_LEN_LONG  = 3'd3;

    // Request kinds
    localparam logic REQ_MIDI = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] REG_OCTAVE    = 2'd0;
    localparam logic [1:0] REG_SEMITONE  = 2'd1;
    localparam logic [1:0] REG_CENT      = 2'd2;
    localparam logic [1:0] REG_RETRIGGER = 2'd3;

    // Pitch scaling
    localparam logic signed [15:0] CENTS_PER_SEMI = 16'sd100;

    // One decoded request for the voice state
    typedef struct packed {
        logic note_on;
        logic note_off;
        logic clear;
        logic tick;
    } t_cmd;

    // Voice outputs seen by a tick
    typedef struct packed {
        logic [6:0] note;
        logic [6:0] velocity;
        logic       gate;
    } t_voice_status;

endpackage

// ----- src/mmc_pitch.sv -----
module mmc_pitch
    import mmc_pkg::*;
(
    input  logic signed [2:0]  i_octave,
    input  logic signed [4:0]  i_semitone,
    input  logic signed [7:0]  i_cent,
    input  logic        [6:0]  i_note,
    output logic signed [15:0] o_pitch_cents
);

    logic signed [8:0]  w_oct_ext;
    logic signed [8:0]  w_oct_semis;
    logic signed [8:0]  w_semis;
    logic signed [15:0] w_semis_ext;
    logic signed [15:0] w_semi_cents;

    // Sum semitones: twelve per octave (8x + 4x), then offset and note
    assign w_oct_ext   = {{6{i_octave[2]}}, i_octave};
    assign w_oct_semis = (w_oct_ext <<< 3) + (w_oct_ext <<< 2);
    assign w_semis     = w_oct_semis + {{4{i_semitone[4]}}, i_semitone} + {2'b00, i_note};

    // Scale to cents and add the fine offset
    assign w_semis_ext   = {{7{w_semis[8]}}, w_semis};
    assign w_semi_cents  = w_semis_ext * CENTS_PER_SEMI;
    assign o_pitch_cents = w_semi_cents + {{8{i_cent[7]}}, i_cent};

endmodule

// ----- src/mmc_voice.sv -----
`include "mono_midi_to_cv_converter_top_macros.svh"

module mmc_voice
    import mmc_pkg::*;
#(
    parameter int SLOT_COUNT = 8
)
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cmd          i_cmd,
    input  logic [6:0]    i_note,
    input  logic [6:0]    i_velocity,
    input  logic          i_retrig_en,
    output t_voice_status o_status
);

    logic [SLOT_COUNT-1:0] r_valid;
    logic [SLOT_COUNT-1:0] n_valid;
    logic [6:0]            r_slot_note [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] n_slot_we;
    logic [6:0]            r_cur_note;
    logic [6:0]            n_cur_note;
    logic [6:0]            r_cur_vel;
    logic [6:0]            n_cur_vel;
    logic                  r_pending;
    logic                  n_pending;
    logic                  w_any;
    logic                  w_found;

    assign w_any = |r_valid;

    // Work out the next voice state for the request in flight
    always_comb begin
        n_valid    = r_valid;
        n_slot_we  = '0;
        n_cur_note = r_cur_note;
        n_cur_vel  = r_cur_vel;
        n_pending  = r_pending;
        w_found    = 1'b0;
        if (i_cmd.note_on) begin
            // take the lowest free slot; if none is free the note gets no slot but still becomes current
            for (int i = 0; i < SLOT_COUNT; i++) begin
                if (!r_valid[i] && !w_found) begin
                    n_valid[i]   = 1'b1;
                    n_slot_we[i] = 1'b1;
                    w_found      = 1'b1;
                end
            end
            n_cur_note = i_note;
            n_cur_vel  = i_velocity;
            n_pending  = 1'b1;
        end else if (i_cmd.note_off) begin
            // free every matching slot, then fall back to the note in the highest occupied slot
            for (int i = 0; i < SLOT_COUNT; i++) begin
                if (r_valid[i] && r_slot_note[i] == i_note) begin
                    n_valid[i] = 1'b0;
                end
            end
            for (int i = 0; i < SLOT_COUNT; i++) begin
                if (n_valid[i]) begin
                    n_cur_note = r_slot_note[i];
                end
            end
        end else if (i_cmd.clear) begin
            n_valid    = '0;
            n_cur_note = '0;
            n_cur_vel  = '0;
            n_pending  = 1'b0;
        end else if (i_cmd.tick) begin
            if (!w_any) begin
                n_cur_vel = '0;
            end
            if (i_retrig_en && r_pending) begin
                n_pending = 1'b0;
            end
        end
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_cur_note <= '0;
            r_cur_vel  <= '0;
            r_pending  <= 1'b0;
        end else begin
            r_valid    <= n_valid;
            r_cur_note <= n_cur_note;
            r_cur_vel  <= n_cur_vel;
            r_pending  <= n_pending;
        end
    end

    // Store notes in their slots
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (n_slot_we[i]) begin
                r_slot_note[i] <= i_note;
            end
        end
    end

    // Present what a tick reports
    assign o_status.note     = r_cur_note;
    assign o_status.velocity = w_any ? r_cur_vel : 7'd0;
    assign o_status.gate     = w_any && !(i_retrig_en && r_pending);

    `MMC_ASSERT_NEXT(a_clear_empties, i_clk, i_rst_n, i_cmd.clear, r_valid == '0, "all notes off left a slot occupied")
    `MMC_ASSERT_NEXT(a_note_on_fills, i_clk, i_rst_n, i_cmd.note_on && !(&r_valid), $countones(r_valid) == $past($countones(r_valid)) + 1, "note-on did not take exactly one slot")

endmodule

// ----- src/mono_midi_to_cv_converter_top.sv -----
// A tick request goes through the input register, then the result register.
// Throughput: one request per cycle while o_stall is low; MIDI requests give no result.
// MIDI requests never wait in the input register; a tick waits there only while the
// result register is full and stalled. Reset (i_rst_n low, synchronous): all slots empty,
// note, velocity, retrigger and offsets cleared, both pipeline registers empty.
`include "mono_midi_to_cv_converter_top_macros.svh"

module mono_midi_to_cv_converter_top
    import mmc_pkg::*;
#(
    parameter int SLOT_COUNT = 8
)
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [7:0]         i_cfg_data,
    // request channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_req_type,
    input  logic [2:0]         i_msg_length,
    input  logic [7:0]         i_status_byte,
    input  logic [6:0]         i_data_one,
    input  logic [6:0]         i_data_two,
    // result channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_pitch_cents,
    output logic [6:0]         o_velocity_level,
    output logic               o_gate
);

    logic signed [2:0]  r_octave;
    logic signed [4:0]  r_semitone;
    logic signed [7:0]  r_cent;
    logic               r_retrig_en;

    logic               r_in_valid;
    logic               n_in_valid;
    logic               r_req_type;
    logic [2:0]         r_msg_length;
    logic [7:0]         r_status_byte;
    logic [6:0]         r_data_one;
    logic [6:0]         r_data_two;

    logic               r_out_valid;
    logic               n_out_valid;
    logic signed [15:0] r_pitch_cents;
    logic [6:0]         r_velocity_level;
    logic               r_gate;

    logic               w_accept;
    logic               w_advance;
    logic               w_len_ok;
    logic [3:0]         w_nibble;
    t_cmd               w_cmd;
    t_voice_status      w_status;
    logic signed [15:0] w_pitch;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_octave    <= '0;
            r_semitone  <= '0;
            r_cent      <= '0;
            r_retrig_en <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_OCTAVE:    r_octave    <= i_cfg_data[2:0];
                REG_SEMITONE:  r_semitone  <= i_cfg_data[4:0];
                REG_CENT:      r_cent      <= i_cfg_data;
                REG_RETRIGGER: r_retrig_en <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Advance the input stage: MIDI always, a tick when the result register frees up
    assign w_advance = r_in_valid && (r_req_type == REQ_MIDI || !r_out_valid || !i_stall);
    assign o_stall   = r_in_valid && !w_advance;
    assign w_accept  = i_valid && !o_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_accept) begin
            n_in_valid = 1'b1;
        end else if (w_advance) begin
            n_in_valid = 1'b0;
        end
    end

    // Capture the request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req_type    <= i_req_type;
            r_msg_length  <= i_msg_length;
            r_status_byte <= i_status_byte;
            r_data_one    <= i_data_one;
            r_data_two    <= i_data_two;
        end
    end

    // Decode the request into a voice command
    assign w_nibble = r_status_byte[7:4];
    assign w_len_ok = (r_msg_length == MSG_LEN_SHORT) || (r_msg_length == MSG_LEN_LONG);

    always_comb begin
        w_cmd = '0;
        if (w_advance) begin
            if (r_req_type == REQ_TICK) begin
                w_cmd.tick = 1'b1;
            end else if (w_len_ok) begin
                case (w_nibble)
                    NIB_NOTE_ON:  w_cmd.note_on  = 1'b1;
                    NIB_NOTE_OFF: w_cmd.note_off = 1'b1;
                    NIB_CTRL:     w_cmd.clear    = (r_data_one == CC_ALL_NOTES_OFF);
                    default: ;
                endcase
            end
        end
    end

    mmc_voice #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_voice (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_note      (r_data_one),
        .i_velocity  (r_data_two),
        .i_retrig_en (r_retrig_en),
        .o_status    (w_status)
    );

    mmc_pitch u_pitch (
        .i_octave      (r_octave),
        .i_semitone    (r_semitone),
        .i_cent        (r_cent),
        .i_note        (w_status.note),
        .o_pitch_cents (w_pitch)
    );

    // Load the result register on a tick, drop it once taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_cmd.tick) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmd.tick) begin
            r_pitch_cents    <= w_pitch;
            r_velocity_level <= w_status.velocity;
            r_gate           <= w_status.gate;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_pitch_cents    = r_pitch_cents;
    assign o_velocity_level = r_velocity_level;
    assign o_gate           = r_gate;

    `MMC_ASSERT_SAME(a_midi_never_waits, i_clk, i_rst_n, r_in_valid && r_req_type == REQ_MIDI, !o_stall, "MIDI request held in the input stage")
    `MMC_ASSERT_SAME(a_stall_cause, i_clk, i_rst_n, o_stall, r_out_valid && i_stall && r_req_type == REQ_TICK, "input stalled without a blocked result")
    `MMC_ASSERT_NEXT(a_result_from_tick, i_clk, i_rst_n, !r_out_valid && !w_cmd.tick, !r_out_valid, "result appeared without a tick")

endmodule
